### sv/vsa_pkg.sv
`default_nettype none
package vsa_pkg;

    localparam int MAX_ENTRIES_DEF   = 1024;
    localparam int HISTORY_DEPTH_DEF = 16;
    localparam int MAX_SNAPSHOTS_DEF = 256;

    localparam int LEN_W      = 11;
    localparam int LEN_RESET  = 1024;
    localparam int IN_TDATA_W = 56;
    localparam int OUT_TDATA_W = 48;
    localparam int EXT_W      = 17;

    typedef enum logic [1:0] {
        ACT_SET  = 2'd0,
        ACT_SNAP = 2'd1,
        ACT_GET  = 2'd2,
        ACT_NOP  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_HIST_FULL = 2'd2,
        ST_SNAP_LIM  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ENTRY,
        S_SEARCH,
        S_COMPARE,
        S_SNAP,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

### sv/vsa_ram.sv
`default_nettype none
module vsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### sv/versioned_snapshot_array.sv
// sequence: set reads and updates its entry; get reads its entry, then binary-searches its history
// (up to log2(HISTORY_DEPTH)+1 steps); snap reads the entry memory one entry per cycle
// throughput: one item at a time; the next is taken once the result sits in the output register
// reset: synchronous active low; a clearing pass over every entry zeroes the entry memory
// and no transaction is accepted until it ends; history records are not cleared
`default_nettype none
module versioned_snapshot_array #(
    parameter int MAX_ENTRIES   = vsa_pkg::MAX_ENTRIES_DEF,
    parameter int HISTORY_DEPTH = vsa_pkg::HISTORY_DEPTH_DEF,
    parameter int MAX_SNAPSHOTS = vsa_pkg::MAX_SNAPSHOTS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wen,
    input  wire logic [vsa_pkg::LEN_W-1:0]        i_cfg_wdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // index[9:0], value[41:10], snap_number[49:42], zero fill
    input  wire logic [vsa_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // action[1:0]
    input  wire logic [1:0]                       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // read_value[31:0], taken_snapshot[39:32], status[41:40], zero fill
    output logic      [vsa_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import vsa_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SC_W  = $clog2(MAX_SNAPSHOTS + 1);
    localparam int SN_W  = $clog2(MAX_SNAPSHOTS);
    localparam int HA_W  = $clog2(MAX_ENTRIES * HISTORY_DEPTH);
    localparam int E_W   = 33 + CNT_W;
    localparam int H_W   = SN_W + 32;

    t_state r_state, n_state;
    t_action r_act, n_act;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [31:0] r_val, n_val;
    logic [7:0] r_want, n_want;
    logic [IDX_W:0] r_ptr, n_ptr;
    logic r_pv, n_pv;
    logic [IDX_W-1:0] r_paddr, n_paddr;
    logic [CNT_W-1:0] r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic [31:0] r_cand, n_cand;
    logic [HA_W-1:0] r_base, n_base;
    logic r_full, n_full;
    logic [SC_W-1:0] r_snapc, n_snapc;
    logic [LEN_W-1:0] r_len;
    logic [31:0] r_rv, n_rv;
    logic [7:0] r_rt, n_rt;
    t_status r_rs, n_rs;
    logic r_ov, n_ov;
    logic [OUT_TDATA_W-1:0] r_od, n_od;

    logic e_we;
    logic [IDX_W-1:0] e_waddr, e_raddr;
    logic [E_W-1:0] e_wdata, e_rdata;
    logic h_we;
    logic [HA_W-1:0] h_waddr, h_raddr;
    logic [H_W-1:0] h_wdata, h_rdata;

    logic [31:0] e_live;
    logic e_mark;
    logic [CNT_W-1:0] e_count;
    logic [EXT_W-1:0] in_idx_ext, lim_ext;
    logic in_ok;
    logic [IDX_W-1:0] in_addr;
    logic [CNT_W-1:0] mid;
    logic [EXT_W-1:0] snap_cmp, want_cmp, cnt_ext;

    assign e_live  = e_rdata[31:0];
    assign e_mark  = e_rdata[32];
    assign e_count = e_rdata[E_W-1:33];

    assign in_idx_ext = EXT_W'(s_axis_tdata[9:0]);
    assign lim_ext = (EXT_W'(r_len) > EXT_W'(MAX_ENTRIES)) ? EXT_W'(MAX_ENTRIES)
                                                           : EXT_W'(r_len);
    assign in_ok   = in_idx_ext < lim_ext;
    assign in_addr = in_idx_ext[IDX_W-1:0];
    assign mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign snap_cmp = EXT_W'(h_rdata[H_W-1:32]);
    assign want_cmp = EXT_W'(r_want);
    assign cnt_ext  = EXT_W'(r_snapc);

    vsa_ram #(.WIDTH(E_W), .DEPTH(MAX_ENTRIES), .AW(IDX_W)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    vsa_ram #(.WIDTH(H_W), .DEPTH(MAX_ENTRIES * HISTORY_DEPTH), .AW(HA_W)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;

    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        n_idx   = r_idx;
        n_val   = r_val;
        n_want  = r_want;
        n_ptr   = r_ptr;
        n_pv    = r_pv;
        n_paddr = r_paddr;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_cand  = r_cand;
        n_base  = r_base;
        n_full  = r_full;
        n_snapc = r_snapc;
        n_rv    = r_rv;
        n_rt    = r_rt;
        n_rs    = r_rs;
        n_ov    = r_ov && !m_axis_tready;
        n_od    = r_od;
        e_we    = 1'b0;
        e_waddr = r_idx;
        e_wdata = {e_count, 1'b1, r_val};
        e_raddr = in_addr;
        h_we    = 1'b0;
        h_waddr = HA_W'(r_paddr) * HA_W'(HISTORY_DEPTH) + HA_W'(e_count);
        h_wdata = {r_snapc[SN_W-1:0], e_live};
        h_raddr = r_base + HA_W'(mid);

        case (r_state)
            S_CLEAR: begin
                e_we    = 1'b1;
                e_waddr = r_ptr[IDX_W-1:0];
                e_wdata = '0;
                n_ptr   = r_ptr + 1'b1;
                if (r_ptr == (IDX_W+1)'(MAX_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_act  = t_action'(s_axis_tuser);
                    n_idx  = in_addr;
                    n_val  = s_axis_tdata[41:10];
                    n_want = s_axis_tdata[49:42];
                    n_rv   = '0;
                    n_rt   = '0;
                    n_rs   = ST_OK;
                    n_full = 1'b0;
                    case (t_action'(s_axis_tuser))
                        ACT_SET, ACT_GET: begin
                            if (in_ok) begin
                                n_state = S_ENTRY;
                            end else begin
                                n_rs    = ST_BAD_INDEX;
                                n_state = S_DONE;
                            end
                        end
                        ACT_SNAP: begin
                            if (r_snapc >= SC_W'(MAX_SNAPSHOTS)) begin
                                n_rs    = ST_SNAP_LIM;
                                n_state = S_DONE;
                            end else begin
                                e_raddr = '0;
                                n_ptr   = (IDX_W+1)'(1);
                                n_pv    = 1'b1;
                                n_paddr = '0;
                                n_state = S_SNAP;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_ENTRY: begin
                if (r_act == ACT_SET) begin
                    e_we    = (e_live != r_val);
                    n_state = S_DONE;
                end else begin
                    n_lo    = '0;
                    n_hi    = e_count;
                    n_cand  = '0;
                    n_base  = HA_W'(r_idx) * HA_W'(HISTORY_DEPTH);
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (r_lo < r_hi) begin
                    n_mid   = mid;
                    n_state = S_COMPARE;
                end else begin
                    n_rv    = r_cand;
                    n_state = S_DONE;
                end
            end
            S_COMPARE: begin
                // the last record at or below the wanted snapshot is the answer
                if (snap_cmp <= want_cmp) begin
                    n_lo   = r_mid + 1'b1;
                    n_cand = h_rdata[31:0];
                end else begin
                    n_hi = r_mid;
                end
                n_state = S_SEARCH;
            end
            S_SNAP: begin
                // the entry read in the previous cycle is written back, if marked, while the next is read
                e_waddr = r_paddr;
                e_wdata = {e_count, 1'b0, e_live};
                if (r_pv && e_mark) begin
                    e_we = 1'b1;
                    if (e_count >= CNT_W'(HISTORY_DEPTH)) begin
                        n_full = 1'b1;
                    end else begin
                        h_we    = 1'b1;
                        e_wdata = {e_count + 1'b1, 1'b0, e_live};
                    end
                end
                e_raddr = r_ptr[IDX_W-1:0];
                if (r_ptr < (IDX_W+1)'(MAX_ENTRIES)) begin
                    n_paddr = r_ptr[IDX_W-1:0];
                    n_ptr   = r_ptr + 1'b1;
                    n_pv    = 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
                if (!r_pv) begin
                    n_rt    = cnt_ext[7:0];
                    n_rs    = r_full ? ST_HIST_FULL : ST_OK;
                    n_snapc = r_snapc + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov    = 1'b1;
                    n_od    = {6'b0, r_rs, r_rt, r_rv};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr   <= '0;
            r_pv    <= 1'b0;
            r_snapc <= '0;
            r_ov    <= 1'b0;
            r_len   <= LEN_W'(LEN_RESET);
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_pv    <= n_pv;
            r_snapc <= n_snapc;
            r_ov    <= n_ov;
            if (i_cfg_wen) begin
                r_len <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act   <= n_act;
        r_idx   <= n_idx;
        r_val   <= n_val;
        r_want  <= n_want;
        r_paddr <= n_paddr;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_cand  <= n_cand;
        r_base  <= n_base;
        r_full  <= n_full;
        r_rv    <= n_rv;
        r_rt    <= n_rt;
        r_rs    <= n_rs;
        r_od    <= n_od;
    end

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !s_axis_tready)
        else $error("transaction accepted during clearing pass");

    a_snap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_snapc <= SC_W'(MAX_SNAPSHOTS))
        else $error("snapshot counter past limit");

    a_hist_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        h_we |-> (r_state == S_SNAP && e_count < CNT_W'(HISTORY_DEPTH)))
        else $error("history written without room");

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH || r_state == S_COMPARE) |-> (r_lo <= r_hi))
        else $error("binary search bounds crossed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_axis_tready) |=> (r_ov && $stable(r_od)))
        else $error("stalled result changed");

endmodule
`default_nettype wire

### dv/tb_versioned_snapshot_array.sv
`default_nettype none
module tb_versioned_snapshot_array;
    timeunit 1ns;
    timeprecision 1ps;
    import vsa_pkg::*;

    localparam int N_ENT   = MAX_ENTRIES_DEF;
    localparam int H_DEPTH = HISTORY_DEPTH_DEF;
    localparam int N_SNAP  = MAX_SNAPSHOTS_DEF;
    localparam int STALL_LIMIT = 20000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wen;
    logic [LEN_W-1:0]       i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // index[9:0], value[41:10], snap_number[49:42], zero fill
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // action[1:0]
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // read_value[31:0], taken_snapshot[39:32], status[41:40], zero fill
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    versioned_snapshot_array dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // packed from the top down: status[41:40], taken[39:32], read_value[31:0]
    typedef struct packed {
        t_status     status;
        logic [7:0]  taken;
        logic [31:0] read_value;
    } t_answer;

    // shadow of the block state
    logic [31:0]      live_word [N_ENT];
    bit               dirty     [N_ENT];
    int unsigned      hist_cnt  [N_ENT];
    int unsigned      hist_snap [N_ENT][H_DEPTH];
    logic [31:0]      hist_val  [N_ENT][H_DEPTH];
    int unsigned      snap_ctr;
    logic [LEN_W-1:0] length_reg;

    t_answer     pending_answers[$];
    int unsigned n_errors;
    int unsigned n_items;
    int unsigned n_answers;
    int unsigned n_hist_full;
    int unsigned n_snap_lim;
    int unsigned n_bad_index;
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit index_valid(logic [9:0] idx);
        int unsigned lim;
        lim = (length_reg > N_ENT) ? N_ENT : length_reg;
        return idx < lim;
    endfunction

    function automatic logic [31:0] search_history(logic [9:0] idx, int unsigned want);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = hist_cnt[idx];
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (hist_snap[idx][mid] <= want) lo = mid + 1;
            else hi = mid;
        end
        return (lo == 0) ? 32'd0 : hist_val[idx][lo-1];
    endfunction

    function automatic t_answer predict_answer(t_action act, logic [9:0] idx,
                                               logic [31:0] word, logic [7:0] want);
        t_answer a;
        a = '{read_value: 32'd0, taken: 8'd0, status: ST_OK};
        case (act)
            ACT_SET: begin
                if (!index_valid(idx)) a.status = ST_BAD_INDEX;
                else if (live_word[idx] != word) begin
                    live_word[idx] = word;
                    dirty[idx] = 1'b1;
                end
            end
            ACT_SNAP: begin
                if (snap_ctr >= N_SNAP) a.status = ST_SNAP_LIM;
                else begin
                    for (int i = 0; i < N_ENT; i++) begin
                        if (dirty[i]) begin
                            dirty[i] = 1'b0;
                            if (hist_cnt[i] >= H_DEPTH) a.status = ST_HIST_FULL;
                            else begin
                                hist_snap[i][hist_cnt[i]] = snap_ctr;
                                hist_val[i][hist_cnt[i]] = live_word[i];
                                hist_cnt[i]++;
                            end
                        end
                    end
                    a.taken = snap_ctr[7:0];
                    snap_ctr++;
                end
            end
            ACT_GET: begin
                if (!index_valid(idx)) a.status = ST_BAD_INDEX;
                else a.read_value = search_history(idx, want);
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h (answer %0d)", what, got, want, n_answers);
        n_errors++;
    endtask

    task automatic send_item(t_action act, logic [9:0] idx, logic [31:0] word,
                             logic [7:0] want);
        t_answer a;
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {6'd0, want, word, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        a = predict_answer(act, idx, word, want);
        pending_answers = {pending_answers, a};
        n_items++;
        if (a.status == ST_HIST_FULL) n_hist_full++;
        if (a.status == ST_SNAP_LIM) n_snap_lim++;
        if (a.status == ST_BAD_INDEX) n_bad_index++;
        @(negedge i_clk);
    endtask

    // a snap walks the whole entry memory, so allow that before touching config
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (N_ENT + 20) @(negedge i_clk);
    endtask

    task automatic write_length(int unsigned len);
        wait_drained();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= len[LEN_W-1:0];
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
        length_reg = len[LEN_W-1:0];
    endtask

    task automatic send_random(int unsigned count, int unsigned idx_span);
        int unsigned r;
        logic [9:0] idx;
        logic [31:0] word;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            idx = (r < 90) ? 10'($urandom_range(idx_span - 1)) : 10'($urandom);
            word = ($urandom_range(3) == 0) ? 32'($urandom_range(3)) : 32'($urandom);
            if (r < 45) send_item(ACT_SET, idx, word, 8'($urandom));
            else if (r < 57) send_item(ACT_SNAP, idx, word, 8'($urandom));
            else if (r < 96) send_item(ACT_GET, idx, word, 8'($urandom_range(snap_ctr + 3)));
            else send_item(ACT_NOP, idx, word, 8'($urandom));
        end
    endtask

    task automatic test_directed();
        send_item(ACT_GET, 10'd0, 32'd0, 8'd0);
        send_item(ACT_SET, 10'd0, 32'h8000_0000, 8'd0);
        send_item(ACT_SET, 10'd1023, 32'h7FFF_FFFF, 8'hFF);
        send_item(ACT_SET, 10'd5, 32'd0, 8'd0);
        send_item(ACT_SNAP, 10'd0, 32'd0, 8'd0);
        send_item(ACT_GET, 10'd0, 32'd0, 8'd0);
        send_item(ACT_GET, 10'd1023, 32'd0, 8'hFF);
        send_item(ACT_SET, 10'd0, 32'hFFFF_FFFF, 8'd0);
        send_item(ACT_GET, 10'd0, 32'd0, 8'd200);
        send_item(ACT_SNAP, 10'd0, 32'd0, 8'd0);
        send_item(ACT_GET, 10'd0, 32'd0, 8'd0);
        send_item(ACT_GET, 10'd0, 32'd0, 8'd1);
        send_item(ACT_NOP, 10'h3FF, 32'hFFFF_FFFF, 8'hFF);
        write_length(0);
        send_item(ACT_SET, 10'd0, 32'd7, 8'd0);
        send_item(ACT_GET, 10'd0, 32'd0, 8'd0);
        write_length(2047);
        send_item(ACT_GET, 10'd1023, 32'd0, 8'd0);
        write_length(1);
        send_item(ACT_GET, 10'd1, 32'd0, 8'd0);
        send_item(ACT_SET, 10'd0, 32'h1234_5678, 8'd0);
        write_length(1024);
    endtask

    task automatic test_history_full();
        // one entry changed on every snap overflows its history
        for (int k = 0; k < H_DEPTH + 3; k++) begin
            send_item(ACT_SET, 10'd3, 32'($urandom) | 32'd1 << k, 8'd0);
            send_item(ACT_SNAP, 10'd0, 32'd0, 8'd0);
        end
        for (int k = 0; k < 8; k++) send_item(ACT_GET, 10'd3, 32'd0, 8'($urandom_range(snap_ctr)));
    endtask

    task automatic test_random_phase(int unsigned idle, int unsigned stall, int unsigned count,
                                     int unsigned len);
        idle_pct  = idle;
        stall_pct = stall;
        write_length(len);
        send_random(count, len);
    endtask

    task automatic test_snapshot_limit();
        idle_pct = 0;
        stall_pct = 0;
        while (snap_ctr < N_SNAP) begin
            send_item(ACT_SET, 10'($urandom_range(15)), 32'($urandom), 8'd0);
            send_item(ACT_SNAP, 10'd0, 32'd0, 8'd0);
        end
        // snaps past the limit leave the marks in place
        repeat (3) begin
            send_item(ACT_SET, 10'($urandom_range(15)), 32'($urandom), 8'd0);
            send_item(ACT_SNAP, 10'd0, 32'd0, 8'd0);
        end
        send_random(60, 16);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wen = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        for (int i = 0; i < N_ENT; i++) begin
            live_word[i] = 32'd0;
            dirty[i] = 1'b0;
            hist_cnt[i] = 0;
        end
        snap_ctr = 0;
        length_reg = LEN_RESET;
        idle_pct = 0;
        stall_pct = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_history_full();
        test_random_phase(0, 0, 400, 16);
        test_random_phase(49, 0, 300, 64);
        wait_drained();
        test_random_phase(0, 49, 300, 1024);
        test_random_phase(32, 32, 300, 8);
        test_snapshot_limit();
        wait_drained();
        $display("%0d items, %0d answers checked; history full %0d, snapshot limit %0d,",
                 n_items, n_answers, n_hist_full, n_snap_lim);
        $display("out of range %0d, with several lengths and idle/stall mixes", n_bad_index);
        if (n_errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_answer want;
        t_answer got;
        if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[41:0];
            n_answers++;
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected answer", 64'(got), 64'd0);
            end else begin
                want = pending_answers.pop_front();
                if (got.read_value !== want.read_value)
                    report_mismatch("read_value", 64'(got.read_value), 64'(want.read_value));
                if (got.taken !== want.taken)
                    report_mismatch("taken_snapshot", 64'(got.taken), 64'(want.taken));
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

endmodule
`default_nettype wire
